// ===== src/quaternion_arithmetic_unit_macros.svh =====
// assertion helpers
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/qau_pkg.sv =====
package qau_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PROD = 3'd0, OP_ROT = 3'd1, OP_SUM = 3'd2, OP_DIFF = 3'd3,
    OP_SCALE = 3'd4, OP_DOT = 3'd5, OP_NONE6 = 3'd6, OP_NONE7 = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0] op;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic saturated;
  } out_item_t;
endpackage

// ===== src/quaternion_arithmetic_unit.sv =====
// quaternion arithmetic unit, signed fixed point operands and results
// input channel: in_push / in_full carry one operation (opcode, a, b) per
// transaction; an item is taken on a clock edge with push high and full low
// result channel: out_empty / out_pop; the oldest result sits on out_data
// while empty is low and leaves on an edge with pop high
// a two-entry input queue decouples intake from a five-register pipeline
// throughput: one item per clock when the result channel is not stalled; set
// by the four-deep multiplier pipeline (operand products, matrix build,
// matrix-vector products, final sum)
// reset (rst_n low, synchronous) empties the queue and the pipeline
// when the receiver stalls, the pipeline holds its five items, the queue
// fills and full rises after two further items; no transaction is lost
module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  qau_pkg::in_item_t in_data,
  output logic out_empty,
  input  logic out_pop,
  output qau_pkg::out_item_t out_data
);
  import qau_pkg::*;
  logic q_valid, q_take;
  in_item_t q_data;
  qau_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .q_valid, .q_take, .q_data
  );
  qau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_data,
    .out_empty, .out_pop, .out_data
  );
endmodule

// ===== src/qau_front.sv =====
module qau_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  qau_pkg::in_item_t in_data,
  output logic q_valid,
  input  logic q_take,
  output qau_pkg::in_item_t q_data
);
  import qau_pkg::*;
  in_item_t mem_r [QUEUE_DEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign in_full = (cnt_r == 2'(QUEUE_DEPTH));
  assign wr = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign rd = q_take && q_valid;
  assign q_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= in_data;
  end
endmodule

// ===== src/qau_back.sv =====
module qau_back #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_take,
  input  qau_pkg::in_item_t q_data,
  output logic out_empty,
  input  logic out_pop,
  output qau_pkg::out_item_t out_data
);
  import qau_pkg::*;
  localparam int AW = 68;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [31:0] s32_t;

  function automatic s32_t rnd(input acc_t a, output logic sat);
    acc_t h;
    acc_t s;
    begin
      h = acc_t'(1) <<< (FRAC_BITS - 1);
      s = (a + h) >>> FRAC_BITS;
      sat = 1'b0;
      if (s > acc_t'(32'sh7fffffff)) begin
        sat = 1'b1;
        rnd = 32'sh7fffffff;
      end else if (s < -acc_t'(33'sh080000000)) begin
        sat = 1'b1;
        rnd = 32'sh80000000;
      end else begin
        rnd = s[31:0];
      end
    end
  endfunction

  function automatic s32_t clip(input logic signed [32:0] v, output logic sat);
    begin
      sat = (v[32] != v[31]);
      clip = sat ? (v[32] ? 32'sh80000000 : 32'sh7fffffff) : v[31:0];
    end
  endfunction

  // stage control
  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  logic adv1, adv2, adv3, adv4, adv5;
  assign adv5 = !ov_r || out_pop;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign q_take = adv1;
  assign out_empty = !ov_r;

  // stage 1: products of operand pairs
  in_item_t d1_r;
  logic signed [63:0] pq_r [16];
  logic signed [63:0] pa_r [10];
  s32_t aa [4];
  s32_t bb [4];
  always_comb begin
    aa = '{q_data.a_w, q_data.a_x, q_data.a_y, q_data.a_z};
    bb = '{q_data.b_w, q_data.b_x, q_data.b_y, q_data.b_z};
  end

  // stage 2: sums, matrix entries, linear ops
  op_t op2_r;
  s32_t r2_r [4];
  logic sat2_r;
  s32_t m2_r [9];
  s32_t v2v_r [3];

  // stage 3: matrix times vector products
  op_t op3_r;
  s32_t r3_r [4];
  logic sat3_r;
  logic signed [63:0] mv_r [9];

  // stage 4 to output
  out_item_t o4_r, o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= q_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) ov_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && q_valid) begin
      d1_r <= q_data;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          pq_r[i*4+j] <= 64'(aa[i]) * 64'(bb[j]);
      pa_r[0] <= 64'(aa[0]) * 64'(aa[0]);
      pa_r[1] <= 64'(aa[1]) * 64'(aa[1]);
      pa_r[2] <= 64'(aa[2]) * 64'(aa[2]);
      pa_r[3] <= 64'(aa[3]) * 64'(aa[3]);
      pa_r[4] <= 64'(aa[1]) * 64'(aa[2]);
      pa_r[5] <= 64'(aa[0]) * 64'(aa[3]);
      pa_r[6] <= 64'(aa[1]) * 64'(aa[3]);
      pa_r[7] <= 64'(aa[0]) * 64'(aa[2]);
      pa_r[8] <= 64'(aa[2]) * 64'(aa[3]);
      pa_r[9] <= 64'(aa[0]) * 64'(aa[1]);
    end
  end

  // pq index: a_i * b_j at i*4+j (w x y z)
  always_ff @(posedge clk) begin
    acc_t e [4];
    acc_t mm [9];
    logic s [13];
    logic sa;
    s32_t rr [4];
    s32_t mr [9];
    if (adv2 && v1_r) begin
      for (int i = 0; i < 4; i++) rr[i] = '0;
      for (int i = 0; i < 13; i++) s[i] = 1'b0;
      for (int i = 0; i < 4; i++) e[i] = '0;
      sa = 1'b0;
      mm[0] = acc_t'(pa_r[0]) + acc_t'(pa_r[1]) - acc_t'(pa_r[2]) - acc_t'(pa_r[3]);
      mm[4] = acc_t'(pa_r[0]) - acc_t'(pa_r[1]) + acc_t'(pa_r[2]) - acc_t'(pa_r[3]);
      mm[8] = acc_t'(pa_r[0]) - acc_t'(pa_r[1]) - acc_t'(pa_r[2]) + acc_t'(pa_r[3]);
      mm[1] = (acc_t'(pa_r[4]) - acc_t'(pa_r[5])) <<< 1;
      mm[2] = (acc_t'(pa_r[6]) + acc_t'(pa_r[7])) <<< 1;
      mm[3] = (acc_t'(pa_r[4]) + acc_t'(pa_r[5])) <<< 1;
      mm[5] = (acc_t'(pa_r[8]) - acc_t'(pa_r[9])) <<< 1;
      mm[6] = (acc_t'(pa_r[6]) - acc_t'(pa_r[7])) <<< 1;
      mm[7] = (acc_t'(pa_r[8]) + acc_t'(pa_r[9])) <<< 1;
      for (int i = 0; i < 9; i++) mr[i] = rnd(mm[i], s[i]);
      unique case (op_t'(d1_r.op))
        OP_PROD: begin
          e[0] = acc_t'(pq_r[0]) - acc_t'(pq_r[5]) - acc_t'(pq_r[10]) - acc_t'(pq_r[15]);
          e[1] = acc_t'(pq_r[1]) + acc_t'(pq_r[4]) + acc_t'(pq_r[11]) - acc_t'(pq_r[14]);
          e[2] = acc_t'(pq_r[2]) - acc_t'(pq_r[7]) + acc_t'(pq_r[8]) + acc_t'(pq_r[13]);
          e[3] = acc_t'(pq_r[3]) + acc_t'(pq_r[6]) - acc_t'(pq_r[9]) + acc_t'(pq_r[12]);
          for (int i = 0; i < 4; i++) rr[i] = rnd(e[i], s[9+i]);
        end
        OP_SCALE: begin
          for (int i = 0; i < 4; i++) rr[i] = rnd(acc_t'(pq_r[i*4]), s[9+i]);
        end
        OP_DOT: begin
          e[0] = acc_t'(pq_r[0]) + acc_t'(pq_r[5]) + acc_t'(pq_r[10]) + acc_t'(pq_r[15]);
          rr[0] = rnd(e[0], s[9]);
        end
        OP_SUM: begin
          rr[0] = clip(33'(d1_r.a_w) + 33'(d1_r.b_w), s[9]);
          rr[1] = clip(33'(d1_r.a_x) + 33'(d1_r.b_x), s[10]);
          rr[2] = clip(33'(d1_r.a_y) + 33'(d1_r.b_y), s[11]);
          rr[3] = clip(33'(d1_r.a_z) + 33'(d1_r.b_z), s[12]);
        end
        OP_DIFF: begin
          rr[0] = clip(33'(d1_r.a_w) - 33'(d1_r.b_w), s[9]);
          rr[1] = clip(33'(d1_r.a_x) - 33'(d1_r.b_x), s[10]);
          rr[2] = clip(33'(d1_r.a_y) - 33'(d1_r.b_y), s[11]);
          rr[3] = clip(33'(d1_r.a_z) - 33'(d1_r.b_z), s[12]);
        end
        default: ;
      endcase
      if (op_t'(d1_r.op) == OP_ROT) begin
        for (int i = 0; i < 9; i++) sa = sa | s[i];
      end else begin
        for (int i = 9; i < 13; i++) sa = sa | s[i];
      end
      op2_r <= op_t'(d1_r.op);
      r2_r <= rr;
      sat2_r <= sa;
      m2_r <= mr;
      v2v_r <= '{d1_r.b_x, d1_r.b_y, d1_r.b_z};
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          mv_r[i*3+j] <= 64'(m2_r[i*3+j]) * 64'(v2v_r[j]);
      op3_r <= op2_r;
      r3_r <= r2_r;
      sat3_r <= sat2_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_t t;
    logic s [3];
    s32_t rv [3];
    if (adv4 && v3_r) begin
      for (int i = 0; i < 3; i++) begin
        t = acc_t'(mv_r[i*3]) + acc_t'(mv_r[i*3+1]) + acc_t'(mv_r[i*3+2]);
        rv[i] = rnd(t, s[i]);
      end
      if (op3_r == OP_ROT) begin
        o4_r <= '{r_w: '0, r_x: rv[0], r_y: rv[1], r_z: rv[2],
                  saturated: sat3_r | s[0] | s[1] | s[2]};
      end else begin
        o4_r <= '{r_w: r3_r[0], r_x: r3_r[1], r_y: r3_r[2], r_z: r3_r[3],
                  saturated: sat3_r};
      end
    end
    if (adv5 && v4_r) o_r <= o4_r;
  end
  assign out_data = o_r;
endmodule

// ===== src/qau_checker.sv =====
`include "quaternion_arithmetic_unit_macros.svh"
module qau_checker (
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic out_empty,
  input logic out_pop,
  input qau_pkg::out_item_t out_data
);
  import qau_pkg::*;
  `QAU_ASSERT_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_data))
  `QAU_ASSERT_NEXT(a_rst_empty, clk, 1'b1, !rst_n, out_empty && !in_full)
  `QAU_ASSERT_NEXT(a_no_full, clk, rst_n, out_empty && !in_full, !in_full)
endmodule

bind quaternion_arithmetic_unit qau_checker u_checker (
  .clk, .rst_n, .in_push, .in_full, .out_empty, .out_pop, .out_data
);
